// ===== rtl/lfsa_pkg.sv =====
package lfsa_pkg;

  localparam int unsigned SLOTS     = 64;
  localparam int unsigned SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W     = SLOT_W + 1;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned SLOT_IDX_W = 6;

  typedef struct packed {
    logic in_ready;
    logic rd_en;
    logic latch_hit;
    logic commit;
    logic found;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic hit;
    logic rd_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/lfsa_req_if.sv =====
interface lfsa_req_if;
  logic                         valid;
  logic                         ready;
  logic [lfsa_pkg::TIME_W-1:0]  arrival_time;
  logic [lfsa_pkg::TIME_W-1:0]  departure_time;

  modport source (output valid, output arrival_time, output departure_time, input ready);
  modport sink   (input valid, input arrival_time, input departure_time, output ready);
endinterface

// ===== rtl/lfsa_rsp_if.sv =====
interface lfsa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [lfsa_pkg::SLOT_IDX_W-1:0] slot_index;
  logic                            is_target;
  logic                            table_full;

  modport source (output valid, output slot_index, output is_target, output table_full,
                  input ready);
  modport sink   (input valid, input slot_index, input is_target, input table_full,
                  output ready);
endinterface

// ===== rtl/lfsa_cfg_if.sv =====
interface lfsa_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lfsa_pkg::TIME_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lfsa_ram.sv =====
module lfsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lfsa_ctrl.sv =====
module lfsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lfsa_pkg::dp_sts_t  sts_i,
  output lfsa_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      found_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (sts_i.in_valid) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          priority if (sts_i.hit) begin
            found_q <= 1'b1;
            state_q <= ST_DONE;
          end else if (sts_i.rd_done) begin
            found_q <= 1'b0;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.in_ready  = (state_q == ST_IDLE);
    cmd_o.rd_en     = (state_q == ST_SCAN) && !sts_i.hit && !sts_i.rd_done;
    cmd_o.latch_hit = (state_q == ST_SCAN) && sts_i.hit;
    cmd_o.commit    = (state_q == ST_DONE) && sts_i.out_free;
    cmd_o.found     = found_q;
  end

endmodule

// ===== rtl/lfsa_dp.sv =====
module lfsa_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  lfsa_req_if.sink           req_i,
  lfsa_rsp_if.source         rsp_o,
  lfsa_cfg_if.sink           cfg_i,
  input  lfsa_pkg::ctl_cmd_t cmd_i,
  output lfsa_pkg::dp_sts_t  sts_o
);

  logic [lfsa_pkg::TIME_W-1:0]     target_q;
  logic [lfsa_pkg::TIME_W-1:0]     arr_q;
  logic [lfsa_pkg::TIME_W-1:0]     dep_q;
  logic [lfsa_pkg::CNT_W-1:0]      rd_idx_q;
  logic [lfsa_pkg::SLOT_W-1:0]     rd_addr;
  logic [lfsa_pkg::SLOT_W-1:0]     chk_idx_q;
  logic                            chk_vld_q;
  logic [lfsa_pkg::SLOT_W-1:0]     found_idx_q;
  logic [lfsa_pkg::SLOTS-1:0]      written_q;
  logic [lfsa_pkg::TIME_W-1:0]     ram_rdata;
  logic [lfsa_pkg::TIME_W-1:0]     rel_time;
  logic                            load;
  logic                            ram_we;

  logic                            out_vld_q;
  logic [lfsa_pkg::SLOT_IDX_W-1:0] out_slot_q;
  logic                            out_tgt_q;
  logic                            out_full_q;

  assign req_i.ready = cmd_i.in_ready;
  assign cfg_i.ready = 1'b1;
  assign load        = req_i.valid && cmd_i.in_ready;
  assign rd_addr     = rd_idx_q[lfsa_pkg::SLOT_W-1:0];
  assign ram_we      = cmd_i.commit && cmd_i.found;

  lfsa_ram #(
    .WIDTH (lfsa_pkg::TIME_W),
    .DEPTH (lfsa_pkg::SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (found_idx_q),
    .wdata_i (dep_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign rel_time = written_q[chk_idx_q] ? ram_rdata : '0;

  always_comb begin
    sts_o.in_valid = req_i.valid;
    sts_o.hit      = chk_vld_q && (rel_time <= arr_q);
    sts_o.rd_done  = (rd_idx_q == lfsa_pkg::CNT_W'(lfsa_pkg::SLOTS));
    sts_o.out_free = !out_vld_q || rsp_o.ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      written_q <= '0;
      chk_vld_q <= 1'b0;
      rd_idx_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        target_q <= cfg_i.data;
      end
      chk_vld_q <= cmd_i.rd_en;
      if (load) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd_en) begin
        rd_idx_q <= rd_idx_q + lfsa_pkg::CNT_W'(1);
      end
      if (ram_we) begin
        written_q[found_idx_q] <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      arr_q <= req_i.arrival_time;
      dep_q <= req_i.departure_time;
    end
    if (cmd_i.rd_en) begin
      chk_idx_q <= rd_addr;
    end
    if (cmd_i.latch_hit) begin
      found_idx_q <= chk_idx_q;
    end
    if (cmd_i.commit) begin
      out_slot_q <= cmd_i.found ? lfsa_pkg::SLOT_IDX_W'(found_idx_q) : '0;
      out_full_q <= !cmd_i.found;
      out_tgt_q  <= (arr_q == target_q);
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.slot_index = out_slot_q;
  assign rsp_o.is_target  = out_tgt_q;
  assign rsp_o.table_full = out_full_q;

endmodule

// ===== rtl/lowest_free_slot_allocator.sv =====
// Lowest free slot allocator. Each request (arrival, departure) takes the lowest-numbered
// slot whose release time is at or before its arrival; that slot then holds the departure
// as its new release time. Requests must arrive in nondecreasing arrival order. One result
// is returned per request with the slot index, a target flag (arrival equals the configured
// target arrival) and a full flag (no free slot; nothing allocated, index reads 0). A
// request scans the release-time RAM one entry per cycle from slot 0 through its single
// read port, stopping at the first free slot or after the last slot. All slots are free
// right after reset with no clearing pass. The next request is accepted while the previous
// result waits in the output register. Write the target arrival only while the block
// is idle.
module lowest_free_slot_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  lfsa_req_if.sink   req_i,
  lfsa_rsp_if.source rsp_o,
  lfsa_cfg_if.sink   cfg_i
);

  lfsa_pkg::ctl_cmd_t cmd;
  lfsa_pkg::dp_sts_t  sts;

  lfsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  lfsa_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

// ===== sim/tb_lowest_free_slot_allocator.sv =====
module tb_lowest_free_slot_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT       = 1_000_000;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 168;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct packed {
    logic [lfsa_pkg::SLOT_IDX_W-1:0] slot_index;
    logic                            is_target;
    logic                            table_full;
  } grant_t;

  typedef struct packed {
    logic [lfsa_pkg::TIME_W-1:0] arrival;
    logic [lfsa_pkg::TIME_W-1:0] departure;
    logic                        typed;
    grant_t                      golden;
  } plan_row_t;

  localparam int unsigned N_PLAN = 16;
  localparam plan_row_t DIRECTED [N_PLAN] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{6'd0, 1'b1, 1'b0}},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{6'd0, 1'b1, 1'b0}},
    '{32'h0000_0000, 32'h0000_0005, 1'b1, '{6'd1, 1'b1, 1'b0}},
    '{32'h0000_0004, 32'h0000_0009, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{32'h0000_0005, 32'h0000_0003, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{32'h0000_0005, 32'h0000_0007, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{32'h0000_0002, 32'h0000_0001, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{6'd0, 1'b0, 1'b0}},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{6'd0, 1'b0, 1'b0}},
    '{32'hFFFF_FFFE, 32'h0000_0000, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{32'h0000_000A, 32'h0000_0014, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{32'h0000_0014, 32'h0000_0000, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{6'd0, 1'b0, 1'b0}}
  };

  logic clk_i;
  logic rst_ni;

  lfsa_req_if req_if ();
  lfsa_rsp_if rsp_if ();
  lfsa_cfg_if cfg_if ();

  lowest_free_slot_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  logic [lfsa_pkg::TIME_W-1:0] release_at [lfsa_pkg::SLOTS];
  logic [lfsa_pkg::TIME_W-1:0] target_arr;
  grant_t                      grants_due [$];
  int unsigned                 mismatches;
  int unsigned                 req_idle_pct;
  int unsigned                 rsp_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic grant_t allocate_slot(input logic [lfsa_pkg::TIME_W-1:0] arr,
                                           input logic [lfsa_pkg::TIME_W-1:0] dep);
    grant_t g;
    logic   found;
    g     = '0;
    found = 1'b0;
    for (int i = 0; i < lfsa_pkg::SLOTS; i++) begin
      if (!found && release_at[i] <= arr) begin
        found        = 1'b1;
        release_at[i] = dep;
        g.slot_index = i[lfsa_pkg::SLOT_IDX_W-1:0];
      end
    end
    g.table_full = !found;
    g.is_target  = (arr == target_arr);
    return g;
  endfunction

  function automatic logic [lfsa_pkg::TIME_W-1:0] sat_add(
      input logic [lfsa_pkg::TIME_W-1:0] a,
      input logic [lfsa_pkg::TIME_W-1:0] b);
    logic [lfsa_pkg::TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[lfsa_pkg::TIME_W] ? '1 : s[lfsa_pkg::TIME_W-1:0];
  endfunction

  task automatic send_request(input logic [lfsa_pkg::TIME_W-1:0] arr,
                              input logic [lfsa_pkg::TIME_W-1:0] dep,
                              input logic typed, input grant_t golden);
    grant_t g;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.arrival_time   <= arr;
    req_if.departure_time <= dep;
    do @(posedge clk_i); while (!req_if.ready);
    g = allocate_slot(arr, dep);
    grants_due.push_back(typed ? golden : g);
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_target(input logic [lfsa_pkg::TIME_W-1:0] value);
    hold_until_drained();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    target_arr = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    rsp_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        grant_t got;
        grant_t want;
        got = '{rsp_if.slot_index, rsp_if.is_target, rsp_if.table_full};
        if (grants_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: slot=%0d tgt=%0b full=%0b",
                     got.slot_index, got.is_target, got.table_full);
        end else begin
          want = grants_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch: expected slot=%0d tgt=%0b full=%0b, ",
                        "got slot=%0d tgt=%0b full=%0b"},
                       want.slot_index, want.is_target, want.table_full,
                       got.slot_index, got.is_target, got.table_full);
          end
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin
    logic [lfsa_pkg::TIME_W-1:0] now;
    logic [lfsa_pkg::TIME_W-1:0] arr;
    logic [lfsa_pkg::TIME_W-1:0] dep;
    int unsigned                 left;
    int unsigned                 seg_len;
    int unsigned                 span;
    int unsigned                 gap_max;
    int unsigned                 dur_max;
    int unsigned                 pick;
    logic                        fill;

    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.arrival_time   = '0;
    req_if.departure_time = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.data           = '0;
    req_idle_pct          = 0;
    rsp_stall_pct         = 0;
    mismatches            = 0;
    target_arr            = '0;
    for (int i = 0; i < lfsa_pkg::SLOTS; i++) release_at[i] = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < N_PLAN; r++)
      send_request(DIRECTED[r].arrival, DIRECTED[r].departure,
                   DIRECTED[r].typed, DIRECTED[r].golden);

    now = '0;
    for (int p = 0; p < PHASES; p++) begin
      hold_until_drained();
      case (p % 4)
        0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin req_idle_pct = 71; rsp_stall_pct = 0;  end
        2: begin req_idle_pct = 0;  rsp_stall_pct = 71; end
        default: begin req_idle_pct = 25; rsp_stall_pct = 25; end
      endcase
      if (p == PHASES - 1) begin
        if (now < 32'hFFFF_FF00) now = 32'hFFFF_FF00;
        write_target(32'hFFFF_FFFF);
      end else if (p == 0) begin
        write_target(32'h0000_0000);
      end else begin
        now = sat_add(now, $urandom_range(0, 32'h1FFF_FFFF));
        write_target(now + $urandom_range(0, 3));
      end

      left = ITEMS_PER_PHASE;
      fill = (p == 0);
      while (left > 0) begin
        seg_len = fill ? 72 : $urandom_range(8, 60);
        if (seg_len > left) seg_len = left;
        span    = 1 << $urandom_range(0, 20);
        gap_max = fill ? 0 : span;
        dur_max = span * $urandom_range(1, 100);
        for (int k = 0; k < seg_len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 86) begin
            now = sat_add(now, $urandom_range(0, gap_max));
            arr = now;
            dep = sat_add(arr, $urandom_range(fill ? 1 : 0, dur_max));
          end else if (pick < 91) begin
            arr = now;
            dep = $urandom;
          end else if (pick < 96) begin
            dep = $urandom_range(0, span);
            arr = (now > dep) ? now - dep : '0;
            dep = sat_add(arr, $urandom_range(0, span));
          end else begin
            arr = $urandom;
            dep = $urandom;
          end
          if ($urandom_range(0, 99) < 2) hold_until_drained();
          send_request(arr, dep, 1'b0, '0);
        end
        left -= seg_len;
        fill  = ($urandom_range(0, 9) == 0);
      end
    end

    hold_until_drained();
    repeat (lfsa_pkg::SLOTS + 8) @(posedge clk_i);
    if (mismatches == 0 && grants_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lfsa_pkg.sv
rtl/lfsa_req_if.sv
rtl/lfsa_rsp_if.sv
rtl/lfsa_cfg_if.sv
rtl/lfsa_ram.sv
rtl/lfsa_ctrl.sv
rtl/lfsa_dp.sv
rtl/lowest_free_slot_allocator.sv
sim/tb_lowest_free_slot_allocator.sv
